>>> sv/bpn_pkg.sv
// ----------------------------------------------------------------------------
// bpn_pkg
// shared types and constants of the beam pair normalizer
// ----------------------------------------------------------------------------
package bpn_pkg;

  // field widths
  localparam int unsigned BeamW  = 24;
  localparam int unsigned OutW   = 32;
  localparam int unsigned SumW   = 48;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;

  // opcodes of an input item
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ACCUM = 2'd1;
  localparam logic [1:0] OP_NORM  = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_CROSSTALK = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MODE      = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SKY_NSIDE = 2'd2;

  // detector modes
  localparam logic [1:0] MODE_A_ONLY = 2'd0;
  localparam logic [1:0] MODE_B_ONLY = 2'd1;
  localparam logic [1:0] MODE_BOTH   = 2'd2;

  // reset values
  localparam logic [15:0] CROSSTALK_RST = 16'd0;
  localparam logic [13:0] SKY_NSIDE_RST = 14'd64;

  // norm used by an inactive detector, as scale 10^8 over 2^38
  localparam logic [27:0] INACTIVE_SCALE = 28'd100000000;
  localparam int unsigned InactiveShift  = 38;

  // divider geometry
  localparam int unsigned DivW   = 128;
  localparam int unsigned QuoW   = 33;
  localparam logic [5:0]  DIV_TOP = 6'd32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MIX,
    ST_MAG,
    ST_MULN0,
    ST_MULN1,
    ST_MULD0,
    ST_MULD1,
    ST_PREP,
    ST_DIVINIT,
    ST_DIV,
    ST_STORE,
    ST_EMIT
  } bpn_state_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_SIMPLE,
    DP_MIX,
    DP_MAG,
    DP_MULN0,
    DP_MULN1,
    DP_MULD0,
    DP_MULD1,
    DP_PREP,
    DP_DIVINIT,
    DP_DIVSTEP,
    DP_STORE,
    DP_LOAD
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   in_ready;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       skip;
    logic       active;
    logic       div_last;
    logic       last_val;
    logic       out_free;
  } dp_status_t;

endpackage

>>> sv/bpn_ctrl.sv
// ----------------------------------------------------------------------------
// bpn_ctrl
// sequencer that steps the datapath through clear, accumulate and the
// eight-value normalize loop
// ----------------------------------------------------------------------------
module bpn_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  bpn_pkg::dp_status_t status_i,
  output bpn_pkg::dp_cmd_t    cmd_o
);
  import bpn_pkg::*;

  bpn_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC:    state_d = (status_i.opcode == OP_NORM) ? ST_MIX : ST_IDLE;
      ST_MIX:     state_d = ST_MAG;
      ST_MAG:     state_d = ST_MULN0;
      ST_MULN0:   state_d = status_i.skip ? ST_STORE : ST_MULN1;
      ST_MULN1:   state_d = status_i.active ? ST_MULD0 : ST_PREP;
      ST_MULD0:   state_d = ST_MULD1;
      ST_MULD1:   state_d = ST_PREP;
      ST_PREP:    state_d = ST_DIVINIT;
      ST_DIVINIT: state_d = ST_DIV;
      ST_DIV:     if (status_i.div_last) state_d = ST_STORE;
      ST_STORE:   state_d = status_i.last_val ? ST_EMIT : ST_MIX;
      ST_EMIT:    if (status_i.out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o.op       = DP_NOP;
    cmd_o.in_ready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) cmd_o.op = DP_CAPTURE;
      end
      ST_EXEC:    cmd_o.op = DP_SIMPLE;
      ST_MIX:     cmd_o.op = DP_MIX;
      ST_MAG:     cmd_o.op = DP_MAG;
      ST_MULN0:   cmd_o.op = status_i.skip ? DP_NOP : DP_MULN0;
      ST_MULN1:   cmd_o.op = DP_MULN1;
      ST_MULD0:   cmd_o.op = DP_MULD0;
      ST_MULD1:   cmd_o.op = DP_MULD1;
      ST_PREP:    cmd_o.op = DP_PREP;
      ST_DIVINIT: cmd_o.op = DP_DIVINIT;
      ST_DIV:     cmd_o.op = DP_DIVSTEP;
      ST_STORE:   cmd_o.op = DP_STORE;
      ST_EMIT:    if (status_i.out_free) cmd_o.op = DP_LOAD;
      default:    cmd_o.op = DP_NOP;
    endcase
  end

  // the divider runs exactly until its last step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && status_i.div_last) |=> (state_q == ST_STORE))
    else $error("divider did not hand over to store");

  // a new item is taken only from idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == DP_CAPTURE) |=> (state_q == ST_EXEC))
    else $error("capture without execute");

  // the result is loaded only when the output side is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == DP_LOAD) |-> (state_q == ST_EMIT && status_i.out_free))
    else $error("result load while output busy");

endmodule

>>> sv/bpn_datapath.sv
// ----------------------------------------------------------------------------
// bpn_datapath
// sums, crosstalk mixing, shared 24x28 multiplier, restoring divider and
// result registers
// ----------------------------------------------------------------------------
module bpn_datapath #(
  parameter int unsigned NSIDE    = 64,
  parameter int unsigned OUT_FRAC = 40
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bpn_pkg::dp_cmd_t           cmd_i,
  output bpn_pkg::dp_status_t        status_o,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [15:0]                cfg_data_i,
  input  logic [1:0]                 opcode_i,
  input  logic signed [23:0]         intensity_a_i,
  input  logic signed [23:0]         stokes_q_a_i,
  input  logic signed [23:0]         stokes_u_a_i,
  input  logic signed [23:0]         stokes_v_a_i,
  input  logic signed [23:0]         intensity_b_i,
  input  logic signed [23:0]         stokes_q_b_i,
  input  logic signed [23:0]         stokes_u_b_i,
  input  logic signed [23:0]         stokes_v_b_i,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output logic signed [31:0]         norm_intensity_a_o,
  output logic signed [31:0]         norm_q_a_o,
  output logic signed [31:0]         norm_u_a_o,
  output logic signed [31:0]         norm_v_a_o,
  output logic signed [31:0]         norm_intensity_b_o,
  output logic signed [31:0]         norm_q_b_o,
  output logic signed [31:0]         norm_u_b_o,
  output logic signed [31:0]         norm_v_b_o,
  output logic                       fault_o
);
  import bpn_pkg::*;

  localparam logic [27:0] NsideSq = 28'(NSIDE * NSIDE);
  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};
  localparam logic [OutW-1:0] OutMax = 32'h7FFF_FFFF;
  localparam logic [OutW-1:0] OutMin = 32'h8000_0000;

  // configuration
  logic [15:0] cross_q;
  logic [1:0]  mode_q;
  logic [13:0] sky_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cross_q <= CROSSTALK_RST;
      mode_q  <= MODE_BOTH;
      sky_q   <= SKY_NSIDE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CROSSTALK: cross_q <= cfg_data_i;
        CFG_MODE:      mode_q  <= cfg_data_i[1:0];
        CFG_SKY_NSIDE: sky_q   <= cfg_data_i[13:0];
        default:       ;
      endcase
    end
  end

  logic act_a, act_b;
  assign act_a = (mode_q != MODE_B_ONLY);
  assign act_b = (mode_q != MODE_A_ONLY);

  // captured item; value arrays rotate so the current kind sits at slot 0
  logic [1:0]              opc_q;
  logic signed [BeamW-1:0] va_q [4];
  logic signed [BeamW-1:0] vb_q [4];
  logic [2:0]              idx_q;   // {kind, detector}

  // running sums
  logic signed [SumW-1:0] sum_a_q, sum_b_q;
  logic signed [SumW:0]   acc_a, acc_b;

  assign acc_a = (SumW+1)'(sum_a_q) + (SumW+1)'(va_q[0]);
  assign acc_b = (SumW+1)'(sum_b_q) + (SumW+1)'(vb_q[0]);

  function automatic logic signed [SumW-1:0] sat_sum(input logic signed [SumW:0] s);
    if (s > (SumW+1)'(SumMax)) return SumMax;
    if (s < (SumW+1)'(SumMin)) return SumMin;
    return s[SumW-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_a_q <= '0;
      sum_b_q <= '0;
    end else if (cmd_i.op == DP_SIMPLE) begin
      case (opc_q)
        OP_CLEAR: begin
          sum_a_q <= '0;
          sum_b_q <= '0;
        end
        OP_ACCUM: begin
          if (act_a) sum_a_q <= sat_sum(acc_a);
          if (act_b) sum_b_q <= sat_sum(acc_b);
        end
        default: ;
      endcase
    end
  end

  // item capture and rotation after each kind
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_CAPTURE) begin
      opc_q    <= opcode_i;
      va_q[0]  <= intensity_a_i;
      va_q[1]  <= stokes_q_a_i;
      va_q[2]  <= stokes_u_a_i;
      va_q[3]  <= stokes_v_a_i;
      vb_q[0]  <= intensity_b_i;
      vb_q[1]  <= stokes_q_b_i;
      vb_q[2]  <= stokes_u_b_i;
      vb_q[3]  <= stokes_v_b_i;
    end else if (cmd_i.op == DP_STORE && idx_q[0]) begin
      for (int k = 0; k < 3; k++) begin
        va_q[k] <= va_q[k+1];
        vb_q[k] <= vb_q[k+1];
      end
      va_q[3] <= va_q[0];
      vb_q[3] <= vb_q[0];
    end
  end

  // mixing: x*2^16 +/- crosstalk*y
  logic                    det_b;
  logic [1:0]              kind;
  logic                    plus;
  logic signed [BeamW-1:0] x_val, y_val;
  logic signed [40:0]      cy;
  logic signed [41:0]      mixed_d, mixed_q;

  assign det_b = idx_q[0];
  assign kind  = idx_q[2:1];
  assign plus  = (kind == 2'd0) || (kind == 2'd3);
  assign x_val = det_b ? vb_q[0] : va_q[0];
  assign y_val = det_b ? va_q[0] : vb_q[0];
  assign cy    = $signed({1'b0, cross_q}) * y_val;
  assign mixed_d = plus ? ((42'(x_val) <<< 16) + 42'(cy))
                        : ((42'(x_val) <<< 16) - 42'(cy));

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_MIX) mixed_q <= mixed_d;
  end

  // magnitudes, signs and special cases
  logic                   cur_act;
  logic signed [SumW-1:0] cur_sum;
  logic [41:0]            mag_w;
  logic [SumW-1:0]        mag_q, smag_q;
  logic                   neg_q, mixneg_q, zn_q, mag0_q, act_q;
  logic [27:0]            sky2_q;

  assign cur_act = det_b ? act_b : act_a;
  assign cur_sum = det_b ? sum_b_q : sum_a_q;
  assign mag_w   = mixed_q[41] ? 42'(-mixed_q) : 42'(mixed_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_MAG) begin
      mag_q    <= SumW'(mag_w);
      mag0_q   <= (mag_w == '0);
      mixneg_q <= mixed_q[41];
      neg_q    <= mixed_q[41] ^ (cur_act & cur_sum[SumW-1]);
      act_q    <= cur_act;
      zn_q     <= cur_act & ((cur_sum == '0) || (sky_q == '0));
      smag_q   <= cur_sum[SumW-1] ? SumW'(-cur_sum) : SumW'(cur_sum);
      sky2_q   <= 28'(sky_q * sky_q);
    end
  end

  // shared multiplier, 48-bit operand in two 24-bit halves
  logic [23:0] mul_a;
  logic [27:0] mul_b;
  logic [51:0] mul_p;
  logic [75:0] pn_q, pd_q;

  always_comb begin
    mul_a = mag_q[23:0];
    mul_b = act_q ? NsideSq : INACTIVE_SCALE;
    case (cmd_i.op)
      DP_MULN1: mul_a = mag_q[47:24];
      DP_MULD0: begin
        mul_a = smag_q[23:0];
        mul_b = sky2_q;
      end
      DP_MULD1: begin
        mul_a = smag_q[47:24];
        mul_b = sky2_q;
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_MULN0: pn_q <= 76'(mul_p);
      DP_MULN1: pn_q <= pn_q + (76'(mul_p) << 24);
      DP_MULD0: pd_q <= 76'(mul_p);
      DP_MULD1: pd_q <= pd_q + (76'(mul_p) << 24);
      default: ;
    endcase
  end

  // divider operands: round(n/d) = floor((2n+d)/(2d))
  logic [DivW-1:0] n_w, d_w;
  logic [DivW-1:0] num_q, den_q, rem_q, dsh_q;
  logic [QuoW-1:0] quo_q;
  logic            ovf_q;
  logic [5:0]      cnt_q;
  logic            rem_ge;

  assign n_w    = DivW'(pn_q) << OUT_FRAC;
  assign d_w    = act_q ? (DivW'(pd_q) << 16) : (DivW'(1) << InactiveShift);
  assign rem_ge = (rem_q >= dsh_q);

  // one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_PREP: begin
        num_q <= (n_w << 1) + d_w;
        den_q <= d_w << 1;
      end
      DP_DIVINIT: begin
        ovf_q <= (num_q >= (den_q << QuoW));
        rem_q <= num_q;
        dsh_q <= den_q << DIV_TOP;
        quo_q <= '0;
        cnt_q <= DIV_TOP;
      end
      DP_DIVSTEP: begin
        if (rem_ge) rem_q <= rem_q - dsh_q;
        quo_q <= {quo_q[QuoW-2:0], rem_ge};
        dsh_q <= dsh_q >> 1;
        cnt_q <= cnt_q - 6'd1;
      end
      default: ;
    endcase
  end

  // saturating encode of one value
  logic [OutW-1:0] enc_val;
  logic            enc_fault;

  always_comb begin
    enc_val   = '0;
    enc_fault = 1'b0;
    if (zn_q) begin
      enc_fault = 1'b1;
      if (!mag0_q) enc_val = mixneg_q ? OutMin : OutMax;
    end else if (mag0_q) begin
      enc_val = '0;
    end else if (!neg_q) begin
      if (ovf_q || (quo_q > QuoW'(OutMax))) begin
        enc_val   = OutMax;
        enc_fault = 1'b1;
      end else begin
        enc_val = quo_q[OutW-1:0];
      end
    end else begin
      if (ovf_q || (quo_q > QuoW'(OutMin))) begin
        enc_val   = OutMin;
        enc_fault = 1'b1;
      end else begin
        enc_val = OutW'(-quo_q[OutW-1:0]);
      end
    end
  end

  // result collection
  logic [OutW-1:0] res_q [8];
  logic            fault_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      fault_q <= 1'b0;
    end else if (cmd_i.op == DP_CAPTURE) begin
      idx_q   <= '0;
      fault_q <= 1'b0;
    end else if (cmd_i.op == DP_STORE) begin
      idx_q   <= idx_q + 3'd1;
      fault_q <= fault_q | enc_fault;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_STORE) res_q[{det_b, kind}] <= enc_val;
  end

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == DP_LOAD) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_LOAD) begin
      norm_intensity_a_o <= res_q[0];
      norm_q_a_o         <= res_q[1];
      norm_u_a_o         <= res_q[2];
      norm_v_a_o         <= res_q[3];
      norm_intensity_b_o <= res_q[4];
      norm_q_b_o         <= res_q[5];
      norm_u_b_o         <= res_q[6];
      norm_v_b_o         <= res_q[7];
      fault_o            <= fault_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // status to the sequencer
  assign status_o.opcode   = opc_q;
  assign status_o.skip     = zn_q | mag0_q;
  assign status_o.active   = act_q;
  assign status_o.div_last = (cnt_q == '0);
  assign status_o.last_val = (idx_q == 3'd7);
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  // a quotient past 33 bits always saturates and flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == DP_STORE && !zn_q && !mag0_q && ovf_q) |=> fault_q)
    else $error("overflowed quotient not flagged");

  // sums move only on clear or accumulate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op != DP_SIMPLE) |=> ($stable(sum_a_q) && $stable(sum_b_q)))
    else $error("sum changed outside clear or accumulate");

  // the held result is never overwritten while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == DP_LOAD) |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");

endmodule

>>> sv/beam_pair_normalizer.sv
// ----------------------------------------------------------------------------
// beam_pair_normalizer
// normalizes detector a/b beam values by their summed intensity
//
//   channel   handshake                    payload
//   in        in_valid_i / in_stall_o      opcode_i, eight Q1.22 beam values
//   out       out_valid_o / out_stall_i    eight norm values, fault_o
//   cfg       cfg_we_i                     cfg_index_i, cfg_data_i
//
// clear and accumulate items finish in the execute state; a normalize item
// passes each value through mixing, the multiplier and the 33-step restoring
// divider shared by all eight values (a zero mix or zero norm skips both)
// one item at a time; a result waits in the output register while the next
// item is already taken; reset is asynchronous, active low, no clearing pass
// ----------------------------------------------------------------------------
module beam_pair_normalizer #(
  parameter int unsigned NSIDE    = 64,
  parameter int unsigned OUT_FRAC = 40
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         opcode_i,
  input  logic signed [23:0] intensity_a_i,
  input  logic signed [23:0] stokes_q_a_i,
  input  logic signed [23:0] stokes_u_a_i,
  input  logic signed [23:0] stokes_v_a_i,
  input  logic signed [23:0] intensity_b_i,
  input  logic signed [23:0] stokes_q_b_i,
  input  logic signed [23:0] stokes_u_b_i,
  input  logic signed [23:0] stokes_v_b_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] norm_intensity_a_o,
  output logic signed [31:0] norm_q_a_o,
  output logic signed [31:0] norm_u_a_o,
  output logic signed [31:0] norm_v_a_o,
  output logic signed [31:0] norm_intensity_b_o,
  output logic signed [31:0] norm_q_b_o,
  output logic signed [31:0] norm_u_b_o,
  output logic signed [31:0] norm_v_b_o,
  output logic               fault_o
);
  import bpn_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  bpn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // arithmetic
  bpn_datapath #(
    .NSIDE    (NSIDE),
    .OUT_FRAC (OUT_FRAC)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .opcode_i           (opcode_i),
    .intensity_a_i      (intensity_a_i),
    .stokes_q_a_i       (stokes_q_a_i),
    .stokes_u_a_i       (stokes_u_a_i),
    .stokes_v_a_i       (stokes_v_a_i),
    .intensity_b_i      (intensity_b_i),
    .stokes_q_b_i       (stokes_q_b_i),
    .stokes_u_b_i       (stokes_u_b_i),
    .stokes_v_b_i       (stokes_v_b_i),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .norm_intensity_a_o (norm_intensity_a_o),
    .norm_q_a_o         (norm_q_a_o),
    .norm_u_a_o         (norm_u_a_o),
    .norm_v_a_o         (norm_v_a_o),
    .norm_intensity_b_o (norm_intensity_b_o),
    .norm_q_b_o         (norm_q_b_o),
    .norm_u_b_o         (norm_u_b_o),
    .norm_v_b_o         (norm_v_b_o),
    .fault_o            (fault_o)
  );

  // input transfer only while the sequencer is idle
  assign in_stall_o = ~cmd.in_ready;

endmodule
